@@ design/d_ary_max_heap_queue_defines.svh @@
// Assertion macros used by the checker file
`ifndef D_ARY_MAX_HEAP_QUEUE_DEFINES_SVH
`define D_ARY_MAX_HEAP_QUEUE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset
`define DAHQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset
`define DAHQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

@@ design/dahq_pkg.sv @@
// ----------------------------------------------------------------------------
// dahq_pkg
// Types and constants of the d-ary max-heap priority queue.
// ----------------------------------------------------------------------------
package dahq_pkg;
   localparam int CAPACITY_DEF  = 256;
   localparam int MAX_ARITY_DEF = 8;
   localparam int KEY_W    = 32;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 3;
   localparam int ARITY_W  = 4;
   localparam logic [ARITY_W-1:0] ARITY_RESET = 4'd3;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT   = 2'd0,
      ACT_EXTRACT  = 2'd1,
      ACT_INCREASE = 2'd2,
      ACT_NOP      = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_OVERFLOW  = 3'd1,
      ST_UNDERFLOW = 3'd2,
      ST_SMALLER   = 3'd3,
      ST_RANGE     = 3'd4
   } status_type;

   // memory port request from the sequencer
   typedef struct packed {
      logic              wr_en;
      logic [15:0]       wr_addr;
      logic [KEY_W-1:0]  wr_data;
      logic [15:0]       rd_addr;
   } mem_req_type;
endpackage

@@ design/d_ary_max_heap_queue.sv @@
// ----------------------------------------------------------------------------
// d_ary_max_heap_queue
// D-ary max-heap priority queue: insert, extract maximum, increase key.
//
//   channel   dir   handshake          payload
//   req_      in    req_valid/ready    action, key, index
//   rsp_      out   rsp_valid/ready    value, status, count
//   csr_      in    csr_wr_en          arity
//
// One request at a time; all heap traffic goes through the one RAM.
// Sift up finds the parent position q of each level by subtracting d once a
// cycle, then reads and compares the parent. Sift down reads the children of
// each level one by one and compares them; extract first fetches root and last
// entry. Every request ends with one done cycle that loads the response
// register. Reset clears the count; RAM contents need none.
// A new request is taken only when the response register is empty or being
// read in the same cycle.
// ----------------------------------------------------------------------------
module d_ary_max_heap_queue #(
   parameter int CAPACITY  = dahq_pkg::CAPACITY_DEF,
   parameter int MAX_ARITY = dahq_pkg::MAX_ARITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [dahq_pkg::ACTION_W-1:0]     req_action,
   input  logic signed [dahq_pkg::KEY_W-1:0] req_key,
   input  logic [$clog2(CAPACITY)-1:0]       req_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [dahq_pkg::KEY_W-1:0] rsp_value,
   output logic [dahq_pkg::STATUS_W-1:0]     rsp_status,
   output logic [$clog2(CAPACITY+1)-1:0]     rsp_count,
   input  logic                              csr_wr_en,
   input  logic [dahq_pkg::ARITY_W-1:0]      csr_wr_data
);
   import dahq_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   logic [ARITY_W-1:0] arity_ff;
   logic idle, done, start;
   logic [KEY_W-1:0] s_value;
   logic [STATUS_W-1:0] s_status;
   logic [$clog2(CAPACITY+1)-1:0] s_count;
   mem_req_type mreq;
   logic [KEY_W-1:0] rd_data;
   logic rsp_valid_ff;

   assign req_ready = idle && (!rsp_valid_ff || rsp_ready);
   assign start     = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         arity_ff <= ARITY_RESET;
      end else if (csr_wr_en) begin
         arity_ff <= csr_wr_data;
      end
   end

   dahq_seq #(.CAPACITY(CAPACITY), .MAX_ARITY(MAX_ARITY)) u_seq (
      .clock, .reset, .arity(arity_ff), .start,
      .action(req_action), .key(req_key), .index(req_index),
      .idle, .done, .value(s_value), .status(s_status), .count(s_count),
      .mem_req(mreq), .rd_data
   );

   dahq_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_ram (
      .clock,
      .wr_en(mreq.wr_en), .wr_addr(mreq.wr_addr[AW-1:0]),
      .wr_data(mreq.wr_data), .rd_addr(mreq.rd_addr[AW-1:0]), .rd_data
   );

   // output register; req_ready keeps a done away from a full register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (done) begin
         rsp_value  <= s_value;
         rsp_status <= s_status;
         rsp_count  <= s_count;
      end
   end
   assign rsp_valid = rsp_valid_ff;
endmodule

@@ design/dahq_ram.sv @@
// ----------------------------------------------------------------------------
// dahq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dahq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ design/dahq_seq.sv @@
// ----------------------------------------------------------------------------
// dahq_seq
// Sequencer for the heap: sift up and sift down through one memory port and
// one shared signed compare unit.
// ----------------------------------------------------------------------------
module dahq_seq #(
   parameter int CAPACITY  = dahq_pkg::CAPACITY_DEF,
   parameter int MAX_ARITY = dahq_pkg::MAX_ARITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [dahq_pkg::ARITY_W-1:0]       arity,
   input  logic                               start,
   input  logic [dahq_pkg::ACTION_W-1:0]      action,
   input  logic signed [dahq_pkg::KEY_W-1:0]  key,
   input  logic [$clog2(CAPACITY)-1:0]        index,
   output logic                               idle,
   output logic                               done,
   output logic signed [dahq_pkg::KEY_W-1:0]  value,
   output logic [dahq_pkg::STATUS_W-1:0]      status,
   output logic [$clog2(CAPACITY+1)-1:0]      count,
   output dahq_pkg::mem_req_type              mem_req,
   input  logic [dahq_pkg::KEY_W-1:0]         rd_data
);
   import dahq_pkg::*;

   localparam int CW = $clog2(CAPACITY+1);
   localparam int DW = $clog2(MAX_ARITY+1);
   // position arithmetic wide enough for d*pos+d
   localparam int PW = CW + DW + 1;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_RDIDX = 11'b00000000010, // increase: read entry at index
      S_CHKIX = 11'b00000000100,
      S_UPDIV = 11'b00000001000, // compute parent by repeated subtraction
      S_UPRD  = 11'b00000010000,
      S_UPCMP = 11'b00000100000,
      S_RDLST = 11'b00001000000, // extract: read root then last
      S_GTLST = 11'b00010000000,
      S_DNRD  = 11'b00100000000, // sink: read one child or write the swap
      S_DNCMP = 11'b01000000000,
      S_DONE  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] pos_ff, pos_in;      // current position
   logic [PW-1:0] aux_ff, aux_in;      // divider remainder / child position
   logic [PW-1:0] quo_ff, quo_in;      // parent quotient / best position
   logic [DW-1:0] j_ff, j_in;          // child number
   logic [KEY_W-1:0] cur_ff, cur_in;   // key that moves
   logic [KEY_W-1:0] best_ff, best_in; // best key seen in sink
   logic [KEY_W-1:0] value_ff, value_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [1:0] phase_ff, phase_in;
   logic [15:0] raddr_ff, raddr_in;    // read address, held until changed
   logic [DW-1:0] d_eff;
   logic less;   // shared compare: a < b signed
   logic [KEY_W-1:0] cmp_a, cmp_b;
   mem_req_type req;

   always_comb begin
      if (int'(arity) < 2) begin
         d_eff = DW'(2);
      end else if (int'(arity) > MAX_ARITY) begin
         d_eff = DW'(MAX_ARITY);
      end else begin
         d_eff = DW'(arity);
      end
   end

   assign less = $signed(cmp_a) < $signed(cmp_b);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      aux_in    = aux_ff;
      quo_in    = quo_ff;
      j_in      = j_ff;
      cur_in    = cur_ff;
      best_in   = best_ff;
      value_in  = value_ff;
      status_in = status_ff;
      phase_in  = phase_ff;
      cmp_a     = rd_data;
      cmp_b     = cur_ff;
      req       = '0;
      req.rd_addr = raddr_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               value_in  = '0;
               status_in = ST_OK;
               cur_in    = key;
               case (action_type'(action))
                  ACT_INSERT: begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        status_in = ST_OVERFLOW;
                        state_in  = S_DONE;
                     end else begin
                        req.wr_en   = 1'b1;
                        req.wr_addr = 16'(count_ff);
                        req.wr_data = key;
                        pos_in      = PW'(count_ff);
                        count_in    = count_ff + CW'(1);
                        state_in    = S_UPDIV;
                        aux_in      = PW'(count_ff) - PW'(1);
                        quo_in      = '0;
                     end
                  end
                  ACT_EXTRACT: begin
                     if (count_ff == '0) begin
                        value_in  = '1;
                        status_in = ST_UNDERFLOW;
                        state_in  = S_DONE;
                     end else begin
                        req.rd_addr = '0;
                        count_in    = count_ff - CW'(1);
                        phase_in    = 2'd0;
                        state_in    = S_RDLST;
                     end
                  end
                  ACT_INCREASE: begin
                     if (CW'(index) >= count_ff) begin
                        status_in = ST_RANGE;
                        state_in  = S_DONE;
                     end else begin
                        req.rd_addr = 16'(index);
                        pos_in      = PW'(index);
                        state_in    = S_RDIDX;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_RDIDX: state_in = S_CHKIX;
         S_CHKIX: begin
            cmp_a = cur_ff;
            cmp_b = rd_data;
            if (less) begin
               status_in = ST_SMALLER;
               state_in  = S_DONE;
            end else begin
               req.wr_en   = 1'b1;
               req.wr_addr = 16'(pos_ff);
               req.wr_data = cur_ff;
               aux_in      = pos_ff - PW'(1);
               quo_in      = '0;
               state_in    = S_UPDIV;
            end
         end
         S_UPDIV: begin
            // parent = (pos-1)/d, one subtraction a cycle
            if (pos_ff == '0) begin
               state_in = S_DONE;
            end else if (aux_ff >= PW'(d_eff)) begin
               aux_in = aux_ff - PW'(d_eff);
               quo_in = quo_ff + PW'(1);
            end else begin
               req.rd_addr = 16'(quo_ff);
               state_in    = S_UPRD;
            end
         end
         S_UPRD: state_in = S_UPCMP;
         S_UPCMP: begin
            cmp_a = rd_data;
            cmp_b = cur_ff;
            if (less) begin
               req.wr_en   = 1'b1;
               req.wr_addr = 16'(pos_ff);
               req.wr_data = rd_data;
               pos_in      = quo_ff;
               aux_in      = quo_ff - PW'(1);
               quo_in      = '0;
               state_in    = S_UPDIV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RDLST: begin
            if (phase_ff == 2'd0) begin
               value_in    = rd_data;
               req.rd_addr = 16'(count_ff);
               phase_in    = 2'd1;
            end else begin
               state_in = S_GTLST;
            end
         end
         S_GTLST: begin
            if (count_ff == '0) begin
               state_in = S_DONE;
            end else begin
               cur_in      = rd_data;
               req.wr_en   = 1'b1;
               req.wr_addr = '0;
               req.wr_data = rd_data;
               pos_in      = '0;
               quo_in      = '0;
               best_in     = rd_data;
               j_in        = '0;
               aux_in      = PW'(1);
               state_in    = S_DNRD;
            end
         end
         S_DNRD: begin
            if (j_ff == d_eff || aux_ff >= PW'(count_ff)) begin
               if (quo_ff == pos_ff) begin
                  state_in = S_DONE;
               end else begin
                  // swap: best child key up, moving key down
                  req.wr_en   = 1'b1;
                  req.wr_addr = 16'(pos_ff);
                  req.wr_data = best_ff;
                  pos_in      = quo_ff;
                  phase_in    = 2'd2;
                  state_in    = S_DNCMP;
               end
            end else begin
               req.rd_addr = 16'(aux_ff);
               phase_in    = 2'd3;
               state_in    = S_DNCMP;
            end
         end
         S_DNCMP: begin
            if (phase_ff == 2'd2) begin
               req.wr_en   = 1'b1;
               req.wr_addr = 16'(pos_ff);
               req.wr_data = cur_ff;
               best_in     = cur_ff;
               j_in        = '0;
               aux_in      = PW'(d_eff) * pos_ff + PW'(1);
               state_in    = S_DNRD;
            end else if (phase_ff == 2'd3) begin
               phase_in = 2'd0;
            end else begin
               cmp_a = best_ff;
               cmp_b = rd_data;
               if (less) begin
                  best_in = rd_data;
                  quo_in  = aux_ff;
               end
               aux_in   = aux_ff + PW'(1);
               j_in     = j_ff + DW'(1);
               state_in = S_DNRD;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      raddr_in = req.rd_addr;
   end

   always_comb begin
      mem_req = req;
      // in sift up the moving key sits at pos after each swap
      if (state_ff == S_UPDIV && !req.wr_en) begin
         mem_req.wr_en   = 1'b1;
         mem_req.wr_addr = 16'(pos_ff);
         mem_req.wr_data = cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         phase_ff <= '0;
         raddr_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
         raddr_ff <= raddr_in;
      end
      pos_ff    <= pos_in;
      aux_ff    <= aux_in;
      quo_ff    <= quo_in;
      j_ff      <= j_in;
      cur_ff    <= cur_in;
      best_ff   <= best_in;
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   assign idle   = state_ff == S_IDLE;
   assign done   = state_ff == S_DONE;
   assign value  = value_ff;
   assign status = status_ff;
   assign count  = count_ff;
endmodule

@@ design/dahq_checker.sv @@
// ----------------------------------------------------------------------------
// dahq_checker
// Port-level checks of the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "d_ary_max_heap_queue_defines.svh"
module dahq_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [31:0] rsp_value
);
   import dahq_pkg::*;

   `DAHQ_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready, "busy")
   `DAHQ_ASSERT_IMPL(a_under, clock, reset, rsp_valid && rsp_status == ST_UNDERFLOW, rsp_value == '1, "underflow value")
   `DAHQ_ASSERT_IMPL(a_stat, clock, reset, rsp_valid, rsp_status <= ST_RANGE, "bad status")
   `DAHQ_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value), "dropped")
endmodule

bind d_ary_max_heap_queue dahq_checker u_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_status, .rsp_value
);
